FILE: rtl/sst_pkg.sv
package sst_pkg;

    localparam int LINE_BITS     = 16;
    localparam int LENGTH_BITS   = 16;
    localparam int KEYWORD_CHARS = 8;
    localparam int MAX_RESULTS   = 4;
    localparam int Q_DEPTH       = 4;
    localparam int Q_AW          = $clog2(Q_DEPTH);

    localparam logic [1:0] REC_TOKEN   = 2'd0;
    localparam logic [1:0] REC_CONTENT = 2'd1;
    localparam logic [1:0] REC_ERROR   = 2'd2;

    typedef struct packed {
        logic [1:0]  rtype;
        logic [5:0]  kind;
        logic [15:0] line;
        logic [15:0] col;
        logic [15:0] len;
        logic [7:0]  cbyte;
        logic [3:0]  code;
    } rec_t;

    typedef struct packed {
        rec_t [MAX_RESULTS-1:0] rec;
        logic [2:0]             n;
    } grp_t;

    typedef struct packed {
        logic not_empty;
        logic full;
    } q_stat_t;

endpackage

FILE: rtl/sst_front.sv
module sst_front (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_stall,
    input  logic [7:0]     in_byte,
    input  sst_pkg::q_stat_t q_stat,
    output logic           push,
    output sst_pkg::grp_t  push_grp
);
    import sst_pkg::*;

    typedef enum logic [3:0] {
        M_START, M_HELD, M_COMMENT, M_IDENT, M_INT, M_DOT, M_FRAC, M_EXP,
        M_EXPSIGN, M_EXPDIG, M_STR, M_ESC, M_HEX1, M_HEX2, M_UBRACE, M_UHEX
    } mode_t;

    typedef enum logic [1:0] {GO_ADV, GO_AGAIN, GO_STOP} go_t;

    localparam logic [3:0] E_BADCHAR = 4'd0;
    localparam logic [3:0] E_UNTERM  = 4'd3;
    localparam logic [3:0] E_ESC     = 4'd4;
    localparam logic [3:0] E_HEX     = 4'd5;
    localparam logic [3:0] E_HEXBIG  = 4'd6;
    localparam logic [3:0] E_BRACE   = 4'd7;
    localparam logic [3:0] E_UHEX    = 4'd8;
    localparam logic [3:0] E_OVF     = 4'd9;

    localparam logic [5:0] K_EOF    = 6'd0;
    localparam logic [5:0] K_NUMBER = 6'd33;
    localparam logic [5:0] K_STRING = 6'd34;
    localparam logic [5:0] K_KW0    = 6'd35;
    localparam logic [5:0] K_IDENT  = 6'd50;

    localparam logic [LINE_BITS-1:0]   LMAX = '1;
    localparam logic [LENGTH_BITS-1:0] NMAX = '1;

    typedef struct packed {
        mode_t                  mode;
        logic [LINE_BITS-1:0]   line;
        logic [LINE_BITS-1:0]   col;
        logic [LINE_BITS-1:0]   sline;
        logic [LINE_BITS-1:0]   scol;
        logic [LENGTH_BITS-1:0] rlen;
        logic [7:0]             held;
        logic [8*KEYWORD_CHARS-1:0] kw;
        logic [23:0]            acc;
        logic                   ovf;
        logic                   halted;
    } scan_st_t;

    localparam scan_st_t ST_RESET = '{
        mode:   M_START,
        line:   LINE_BITS'(1),
        col:    LINE_BITS'(1),
        sline:  LINE_BITS'(1),
        scol:   LINE_BITS'(1),
        rlen:   '0,
        held:   '0,
        kw:     '0,
        acc:    '0,
        ovf:    1'b0,
        halted: 1'b0
    };

    typedef struct packed {
        scan_st_t s;
        go_t      go;
        logic     emit;
        rec_t     rec;
        logic     utf;
    } pass_t;

    function automatic logic [LINE_BITS-1:0] inc_pos(input logic [LINE_BITS-1:0] v);
        return (v == LMAX) ? LMAX : v + 1'b1;
    endfunction

    function automatic logic [LENGTH_BITS-1:0] inc_len(input logic [LENGTH_BITS-1:0] v);
        return (v == NMAX) ? NMAX : v + 1'b1;
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic logic [4:0] hex_val(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (is_digit(c))                r = {1'b1, 4'(c - 8'h30)};
        else if (c >= "a" && c <= "f")  r = {1'b1, 4'(c - 8'h57)};
        else if (c >= "A" && c <= "F")  r = {1'b1, 4'(c - 8'h37)};
        return r;
    endfunction

    // found bit, then index into the two-character operator list
    function automatic logic [4:0] op_index(input logic [7:0] c);
        logic [4:0] r;
        unique case (c)
            "|":     r = {1'b1, 4'd0};
            "&":     r = {1'b1, 4'd1};
            "=":     r = {1'b1, 4'd2};
            "!":     r = {1'b1, 4'd3};
            ">":     r = {1'b1, 4'd4};
            "<":     r = {1'b1, 4'd5};
            ".":     r = {1'b1, 4'd6};
            "+":     r = {1'b1, 4'd7};
            "-":     r = {1'b1, 4'd8};
            "*":     r = {1'b1, 4'd9};
            "/":     r = {1'b1, 4'd10};
            "%":     r = {1'b1, 4'd11};
            default: r = 5'd0;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] op_second(input logic [3:0] i);
        logic [7:0] r;
        unique case (i)
            4'd0:    r = "|";
            4'd1:    r = "&";
            4'd6:    r = ".";
            default: r = "=";
        endcase
        return r;
    endfunction

    // two-character kinds: 10 and 11, then odd kinds from 13
    function automatic logic [5:0] pair_kind(input logic [3:0] i);
        return (i < 4'd2) ? 6'd10 + {2'd0, i} : 6'd9 + {1'b0, i, 1'b0};
    endfunction

    // one-character operator kinds are even from 12
    function automatic logic [5:0] single_op_kind(input logic [3:0] i);
        return 6'd10 + {1'b0, i, 1'b0};
    endfunction

    function automatic logic [5:0] single_kind(input logic [7:0] c);
        logic [5:0] r;
        unique case (c)
            ",":     r = 6'd1;
            ":":     r = 6'd2;
            ";":     r = 6'd3;
            "(":     r = 6'd4;
            ")":     r = 6'd5;
            "[":     r = 6'd6;
            "]":     r = 6'd7;
            "{":     r = 6'd8;
            "}":     r = 6'd9;
            default: r = 6'd0;
        endcase
        return r;
    endfunction

    function automatic logic [63:0] kw_text(input logic [3:0] i);
        logic [63:0] r;
        unique case (i)
            4'd0:    r = 64'("break");
            4'd1:    r = 64'("continue");
            4'd2:    r = 64'("do");
            4'd3:    r = 64'("else");
            4'd4:    r = 64'("false");
            4'd5:    r = 64'("fn");
            4'd6:    r = 64'("if");
            4'd7:    r = 64'("inout");
            4'd8:    r = 64'("let");
            4'd9:    r = 64'("loop");
            4'd10:   r = 64'("nil");
            4'd11:   r = 64'("return");
            4'd12:   r = 64'("true");
            4'd13:   r = 64'("while");
            default: r = 64'("yield");
        endcase
        return r;
    endfunction

    function automatic logic [3:0] kw_len(input logic [3:0] i);
        logic [3:0] r;
        unique case (i)
            4'd1:                      r = 4'd8;
            4'd2, 4'd5, 4'd6:          r = 4'd2;
            4'd8, 4'd10:               r = 4'd3;
            4'd3, 4'd9, 4'd12:         r = 4'd4;
            4'd11:                     r = 4'd6;
            default:                   r = 4'd5;
        endcase
        return r;
    endfunction

    function automatic logic [5:0] kw_kind(input logic [63:0] kw,
                                           input logic [LENGTH_BITS-1:0] len);
        logic [5:0] r;
        r = K_IDENT;
        for (int i = 14; i >= 0; i--) begin
            if (len == LENGTH_BITS'(kw_len(4'(i))) && kw == kw_text(4'(i)))
                r = K_KW0 + 6'(i);
        end
        return r;
    endfunction

    function automatic rec_t mk_tok(input logic [5:0] kind, input logic [LINE_BITS-1:0] ln,
                                    input logic [LINE_BITS-1:0] cl,
                                    input logic [LENGTH_BITS-1:0] len);
        rec_t r;
        r       = '0;
        r.rtype = REC_TOKEN;
        r.kind  = kind;
        r.line  = 16'(ln);
        r.col   = 16'(cl);
        r.len   = 16'(len);
        return r;
    endfunction

    function automatic pass_t fail(input pass_t p, input logic [7:0] c, input logic [3:0] code,
                                   input logic [LINE_BITS-1:0] ln,
                                   input logic [LINE_BITS-1:0] cl);
        pass_t q;
        q          = p;
        q.emit     = 1'b1;
        q.rec      = '0;
        q.rec.rtype = REC_ERROR;
        q.rec.line = 16'(ln);
        q.rec.col  = 16'(cl);
        q.rec.code = code;
        q.go       = GO_STOP;
        if (c == 8'h00) begin
            q.s.mode   = M_START;
            q.s.line   = LINE_BITS'(1);
            q.s.col    = LINE_BITS'(1);
            q.s.halted = 1'b0;
        end else begin
            q.s.halted = 1'b1;
        end
        return q;
    endfunction

    function automatic pass_t content(input pass_t p, input logic [7:0] b);
        pass_t q;
        q           = p;
        q.emit      = 1'b1;
        q.rec       = '0;
        q.rec.rtype = REC_CONTENT;
        q.rec.cbyte = b;
        q.s.rlen    = inc_len(p.s.rlen);
        return q;
    endfunction

    function automatic logic [3:0] char_code(input logic [7:0] c);
        logic [3:0] r;
        if (c == 8'h00)      r = 4'd1;
        else if (c == 8'h0a) r = 4'd2;
        else                 r = E_BADCHAR;
        return r;
    endfunction

    function automatic pass_t scan_pass(input scan_st_t s, input logic [7:0] c);
        pass_t            p;
        logic [4:0]       oi;
        logic [4:0]       oc;
        logic [4:0]       h;
        logic [7:0]       hx;
        logic [LINE_BITS:0] sc;
        p      = '0;
        p.s    = s;
        p.go   = GO_ADV;
        h      = hex_val(c);
        oi     = op_index(s.held);
        oc     = op_index(c);
        hx     = {s.acc[3:0], h[3:0]};
        sc     = '0;
        unique case (s.mode)
            M_START: begin
                if (c == 8'h00) begin
                    p.emit     = 1'b1;
                    p.rec      = mk_tok(K_EOF, s.line, s.col, LENGTH_BITS'(1));
                    p.s.mode   = M_START;
                    p.s.line   = LINE_BITS'(1);
                    p.s.col    = LINE_BITS'(1);
                    p.s.halted = 1'b0;
                    p.go       = GO_STOP;
                end else if (c == " " || (c >= 8'h09 && c <= 8'h0d)) begin
                    p.go = GO_ADV;
                end else if (single_kind(c) != 6'd0) begin
                    p.emit = 1'b1;
                    p.rec  = mk_tok(single_kind(c), s.line, s.col, LENGTH_BITS'(1));
                end else if (oc[4] || is_digit(c) || c == "\"" ||
                             is_alpha(c) || c == "_") begin
                    p.s.sline = s.line;
                    p.s.scol  = s.col;
                    p.s.rlen  = LENGTH_BITS'(1);
                    if (oc[4]) begin
                        p.s.mode = M_HELD;
                        p.s.held = c;
                    end else if (is_digit(c)) begin
                        p.s.mode = M_INT;
                    end else if (c == "\"") begin
                        p.s.mode = M_STR;
                        p.s.rlen = '0;
                    end else begin
                        p.s.mode = M_IDENT;
                        p.s.kw   = 64'(c);
                    end
                end else begin
                    p = fail(p, c, E_BADCHAR, s.line, s.col);
                end
            end
            M_HELD: begin
                if (!oi[4]) begin
                    p.s.mode = M_START;
                    p.go     = GO_AGAIN;
                end else if (oi[3:0] == 4'd10 && c == "/") begin
                    p.s.mode = M_COMMENT;
                end else if (op_second(oi[3:0]) == c) begin
                    p.emit   = 1'b1;
                    p.rec    = mk_tok(pair_kind(oi[3:0]), s.sline, s.scol,
                                      LENGTH_BITS'(2));
                    p.s.mode = M_START;
                end else if (oi[3:0] == 4'd0) begin
                    p = fail(p, c, E_BADCHAR, s.sline, s.scol);
                end else begin
                    p.emit   = 1'b1;
                    p.rec    = mk_tok(single_op_kind(oi[3:0]), s.sline, s.scol,
                                      LENGTH_BITS'(1));
                    p.s.mode = M_START;
                    p.go     = GO_AGAIN;
                end
            end
            M_COMMENT: begin
                if (c == 8'h00) begin
                    p.s.mode = M_START;
                    p.go     = GO_AGAIN;
                end else if (c == 8'h0a) begin
                    p.s.mode = M_START;
                end
            end
            M_IDENT: begin
                if (is_alpha(c) || is_digit(c) || c == "_") begin
                    if (s.rlen < LENGTH_BITS'(KEYWORD_CHARS))
                        p.s.kw = {s.kw[8*KEYWORD_CHARS-9:0], c};
                    p.s.rlen = inc_len(s.rlen);
                end else begin
                    p.emit   = 1'b1;
                    p.rec    = mk_tok(kw_kind(s.kw, s.rlen), s.sline, s.scol, s.rlen);
                    p.s.mode = M_START;
                    p.go     = GO_AGAIN;
                end
            end
            M_DOT: begin
                if (is_digit(c)) begin
                    p.s.rlen = inc_len(s.rlen);
                    p.s.mode = M_FRAC;
                end else begin
                    p.emit   = 1'b1;
                    p.rec    = mk_tok(K_NUMBER, s.sline, s.scol, s.rlen - 1'b1);
                    sc       = {1'b0, s.scol} + (LINE_BITS+1)'(s.rlen) - 1'b1;
                    p.s.scol = sc[LINE_BITS] ? LMAX : sc[LINE_BITS-1:0];
                    p.s.rlen = LENGTH_BITS'(1);
                    p.s.held = ".";
                    p.s.mode = M_HELD;
                    p.go     = GO_AGAIN;
                end
            end
            M_EXP, M_EXPSIGN: begin
                if (s.mode == M_EXP && (c == "+" || c == "-")) begin
                    p.s.rlen = inc_len(s.rlen);
                    p.s.mode = M_EXPSIGN;
                end else if (!is_digit(c)) begin
                    p = fail(p, c, char_code(c), s.line, s.col);
                end else begin
                    p.s.rlen = inc_len(s.rlen);
                    p.s.mode = M_EXPDIG;
                end
            end
            M_INT, M_FRAC, M_EXPDIG: begin
                if (is_digit(c)) begin
                    p.s.rlen = inc_len(s.rlen);
                end else if (s.mode == M_INT && c == ".") begin
                    p.s.rlen = inc_len(s.rlen);
                    p.s.mode = M_DOT;
                end else if (s.mode != M_EXPDIG && (c == "e" || c == "E")) begin
                    p.s.rlen = inc_len(s.rlen);
                    p.s.mode = M_EXP;
                end else if (is_alpha(c) || c == "_") begin
                    p = fail(p, c, E_BADCHAR, s.line, s.col);
                end else begin
                    p.emit   = 1'b1;
                    p.rec    = mk_tok(K_NUMBER, s.sline, s.scol, s.rlen);
                    p.s.mode = M_START;
                    p.go     = GO_AGAIN;
                end
            end
            M_STR: begin
                if (c == 8'h00 || c == 8'h0a) begin
                    p = fail(p, c, E_UNTERM, s.line, s.col);
                end else if (c == "\"") begin
                    p.emit   = 1'b1;
                    p.rec    = mk_tok(K_STRING, s.line, s.col, s.rlen);
                    p.s.mode = M_START;
                end else if (c == "\\") begin
                    p.s.mode = M_ESC;
                end else begin
                    p = content(p, c);
                end
            end
            M_ESC: begin
                p.s.mode = M_STR;
                unique case (c)
                    "n":     p = content(p, 8'h0a);
                    "r":     p = content(p, 8'h0d);
                    "t":     p = content(p, 8'h09);
                    "\"":    p = content(p, c);
                    "\\":    p = content(p, c);
                    "0":     p = content(p, 8'h00);
                    "x":     p.s.mode = M_HEX1;
                    "u":     p.s.mode = M_UBRACE;
                    default: p = fail(p, c, E_ESC, s.line, s.col);
                endcase
            end
            M_HEX1: begin
                if (!h[4]) begin
                    p = fail(p, c, E_HEX, s.line, s.col);
                end else begin
                    p.s.acc   = 24'(h[3:0]);
                    p.s.sline = s.line;
                    p.s.scol  = s.col;
                    p.s.mode  = M_HEX2;
                end
            end
            M_HEX2: begin
                if (!h[4]) begin
                    p = fail(p, c, E_HEX, s.sline, s.scol);
                end else begin
                    p.s.acc = 24'(hx);
                    if (hx[7]) begin
                        p = fail(p, c, E_HEXBIG, s.sline, s.scol);
                    end else begin
                        p        = content(p, hx);
                        p.s.mode = M_STR;
                    end
                end
            end
            M_UBRACE: begin
                if (c != "{") begin
                    p = fail(p, c, E_BRACE, s.line, s.col);
                end else begin
                    p.s.acc  = '0;
                    p.s.ovf  = 1'b0;
                    p.s.mode = M_UHEX;
                end
            end
            M_UHEX: begin
                if (c == "}") begin
                    if (s.ovf || s.acc > 24'h10FFFF) begin
                        p = fail(p, c, E_OVF, s.line, s.col);
                    end else begin
                        p.utf    = 1'b1;
                        p.s.mode = M_STR;
                    end
                end else if (!h[4]) begin
                    p = fail(p, c, E_UHEX, s.line, s.col);
                end else begin
                    p.s.acc = {s.acc[19:0], h[3:0]};
                    if ({s.acc[19:0], h[3:0]} > 24'h10FFFF) begin
                        p.s.ovf = 1'b1;
                        p.s.acc = {4'd0, s.acc[15:0], h[3:0]};
                    end
                end
            end
        endcase
        return p;
    endfunction

    scan_st_t           st_reg;
    scan_st_t           st_next;
    pass_t              p1;
    pass_t              p2;
    pass_t              p3;
    pass_t              fin;
    grp_t               grp;
    logic [2:0]         nres;
    logic [20:0]        cp;
    logic [7:0]         ub [4];
    logic [2:0]         ulen;
    logic [LENGTH_BITS:0] lsum;
    logic               accept;

    assign in_stall = q_stat.full;
    assign accept   = in_valid && !in_stall;

    always_comb begin
        p1      = scan_pass(st_reg, in_byte);
        p2      = scan_pass(p1.s, in_byte);
        p3      = scan_pass(p2.s, in_byte);
        grp     = '0;
        nres    = '0;
        cp      = st_reg.acc[20:0];
        ulen    = 3'd1;
        lsum    = '0;
        ub[0]   = '0;
        ub[1]   = '0;
        ub[2]   = '0;
        ub[3]   = '0;
        fin     = p1;
        if (p1.go == GO_AGAIN) begin
            fin = p2;
            if (p2.go == GO_AGAIN)
                fin = p3;
        end
        st_next = fin.s;

        if (p1.utf) begin
            // expand a braced code point to its UTF-8 bytes
            if (cp <= 21'h7F) begin
                ulen  = 3'd1;
                ub[0] = cp[7:0];
            end else if (cp <= 21'h7FF) begin
                ulen  = 3'd2;
                ub[0] = 8'hC0 | {3'd0, cp[10:6]};
                ub[1] = 8'h80 | {2'd0, cp[5:0]};
            end else if (cp <= 21'hFFFF) begin
                ulen  = 3'd3;
                ub[0] = 8'hE0 | {4'd0, cp[15:12]};
                ub[1] = 8'h80 | {2'd0, cp[11:6]};
                ub[2] = 8'h80 | {2'd0, cp[5:0]};
            end else begin
                ulen  = 3'd4;
                ub[0] = 8'hF0 | {5'd0, cp[20:18]};
                ub[1] = 8'h80 | {2'd0, cp[17:12]};
                ub[2] = 8'h80 | {2'd0, cp[11:6]};
                ub[3] = 8'h80 | {2'd0, cp[5:0]};
            end
            for (int i = 0; i < MAX_RESULTS; i++) begin
                grp.rec[i].rtype = REC_CONTENT;
                grp.rec[i].cbyte = ub[i];
            end
            nres = ulen;
            lsum = {1'b0, p1.s.rlen} + (LENGTH_BITS+1)'(ulen);
            st_next.rlen = lsum[LENGTH_BITS] ? NMAX : lsum[LENGTH_BITS-1:0];
        end else begin
            if (p1.emit) begin
                grp.rec[0] = p1.rec;
                nres       = 3'd1;
            end
            if (p1.go == GO_AGAIN && p2.emit) begin
                grp.rec[nres[1:0]] = p2.rec;
                nres               = nres + 3'd1;
            end
            if (p1.go == GO_AGAIN && p2.go == GO_AGAIN && p3.emit) begin
                grp.rec[nres[1:0]] = p3.rec;
                nres               = nres + 3'd1;
            end
        end

        if (fin.go == GO_ADV) begin
            if (in_byte == 8'h0a) begin
                st_next.line = inc_pos(fin.s.line);
                st_next.col  = LINE_BITS'(1);
            end else begin
                st_next.col  = inc_pos(fin.s.col);
            end
        end

        // halted: drop bytes, byte 0 restarts the next source
        if (st_reg.halted) begin
            st_next = st_reg;
            nres    = '0;
            if (in_byte == 8'h00) begin
                st_next.mode   = M_START;
                st_next.line   = LINE_BITS'(1);
                st_next.col    = LINE_BITS'(1);
                st_next.halted = 1'b0;
            end
        end
        grp.n = nres;
    end

    assign push     = accept && (nres != 3'd0);
    assign push_grp = grp;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            st_reg <= ST_RESET;
        end else if (accept) begin
            st_reg <= st_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && st_reg.halted) |-> !push)
        else $error("result pushed while halted on error");
    assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (grp.n <= 3'(MAX_RESULTS)))
        else $error("result group too large");
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && in_byte == 8'h00) |=> (st_reg.line == LINE_BITS'(1) || st_reg.halted))
        else $error("line not restarted after end of source");

endmodule

FILE: rtl/sst_queue.sv
module sst_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  sst_pkg::grp_t     push_grp,
    input  logic              pop,
    output sst_pkg::q_stat_t  q_stat,
    output sst_pkg::grp_t     head
);
    import sst_pkg::*;

    grp_t            mem [Q_DEPTH];
    logic [Q_AW-1:0] wr_ptr_reg;
    logic [Q_AW-1:0] rd_ptr_reg;
    logic [Q_AW:0]   count_reg;
    logic [Q_AW:0]   count_next;

    assign q_stat.not_empty = (count_reg != '0);
    assign q_stat.full      = (count_reg == (Q_AW+1)'(Q_DEPTH));
    assign head             = mem[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        priority if (push && !pop) count_next = count_reg + 1'b1;
        else if (pop && !push)     count_next = count_reg - 1'b1;
        else                       count_next = count_reg;
    end

    always_ff @(posedge clk) begin
        if (push)
            mem[wr_ptr_reg] <= push_grp;
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) !(push && q_stat.full))
        else $error("push into full queue");
    assert property (@(posedge clk) disable iff (!rst_n) !(pop && !q_stat.not_empty))
        else $error("pop from empty queue");
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (Q_AW+1)'(Q_DEPTH))
        else $error("queue count out of range");

endmodule

FILE: rtl/sst_back.sv
module sst_back (
    input  logic              clk,
    input  logic              rst_n,
    input  sst_pkg::q_stat_t  q_stat,
    input  sst_pkg::grp_t     head,
    output logic              pop,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [1:0]        record_type,
    output logic [5:0]        token_kind,
    output logic [15:0]       token_line,
    output logic [15:0]       token_column,
    output logic [15:0]       token_length,
    output logic [7:0]        content_byte,
    output logic [3:0]        error_code,
    output logic              last_of_run
);
    import sst_pkg::*;

    logic [1:0] idx_reg;
    rec_t       cur;
    logic       take;

    assign out_valid    = q_stat.not_empty;
    assign cur          = head.rec[idx_reg];
    assign last_of_run  = ({1'b0, idx_reg} == head.n - 3'd1);
    assign take         = out_valid && !out_stall;
    assign pop          = take && last_of_run;

    assign record_type  = cur.rtype;
    assign token_kind   = cur.kind;
    assign token_line   = cur.line;
    assign token_column = cur.col;
    assign token_length = cur.len;
    assign content_byte = cur.cbyte;
    assign error_code   = cur.code;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            idx_reg <= '0;
        end else if (take) begin
            idx_reg <= last_of_run ? 2'd0 : idx_reg + 2'd1;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ({1'b0, idx_reg} < head.n))
        else $error("result index beyond group");
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> (idx_reg == 2'd0))
        else $error("result index not cleared while empty");

endmodule

FILE: rtl/script_source_tokenizer.sv
// Streaming tokenizer for script source text.
// Input channel: in_valid / in_stall / in_byte, one source byte per item;
// byte 0 ends a source. Output channel: out_valid / out_stall with one
// record per item (token, decoded string byte or error), last_of_run marking
// the final record caused by one input byte.
// The front scanner classifies each byte in the cycle it is accepted and
// pushes the 0 to 4 records it causes as one group into a 4-entry queue.
// The back drains the queue head one record per cycle while out_stall is low.
// Throughput: one byte per cycle while in_stall is low; a byte that causes
// several records holds the output for each of them in turn, and the queue absorbs that until it fills.
// Receiver stall: the head record holds; once the queue is full in_stall
// rises and the scanner holds its state.
// Reset: scanner at start of token, line and column 1, queue empty.
module script_source_tokenizer (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  in_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  record_type,
    output logic [5:0]  token_kind,
    output logic [15:0] token_line,
    output logic [15:0] token_column,
    output logic [15:0] token_length,
    output logic [7:0]  content_byte,
    output logic [3:0]  error_code,
    output logic        last_of_run
);
    import sst_pkg::*;

    q_stat_t q_stat;
    grp_t    push_grp;
    grp_t    head;
    logic    push;
    logic    pop;

    // scan and classify bytes
    sst_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_byte  (in_byte),
        .q_stat   (q_stat),
        .push     (push),
        .push_grp (push_grp)
    );

    // decouple scanner from output backpressure
    sst_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_grp (push_grp),
        .pop      (pop),
        .q_stat   (q_stat),
        .head     (head)
    );

    // serialize each group into records
    sst_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_stat       (q_stat),
        .head         (head),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .record_type  (record_type),
        .token_kind   (token_kind),
        .token_line   (token_line),
        .token_column (token_column),
        .token_length (token_length),
        .content_byte (content_byte),
        .error_code   (error_code),
        .last_of_run  (last_of_run)
    );

endmodule
